// ===== rtl/ppp_pkg.sv =====
// ----------------------------------------------------------------------------
// ppp_pkg
// Shared widths, register indexes and types of the pinhole point projector.
// ----------------------------------------------------------------------------
package ppp_pkg;

    localparam int DIV_BITS = 22;   // quotient bits kept by the divider
    localparam int DEN_W    = 25;   // positive depth magnitude
    localparam int NUM_W    = 46;   // numerator magnitude

    typedef enum logic [2:0] {
        CFG_ROT_X       = 3'd0,
        CFG_ROT_Y       = 3'd1,
        CFG_ROT_Z       = 3'd2,
        CFG_TRANSLATION = 3'd3,
        CFG_FOCAL       = 3'd4,
        CFG_PRINCIPAL   = 3'd5,
        CFG_IMAGE_SIZE  = 3'd6
    } cfg_index_t;

    // per-item side data riding along the divider stages
    typedef struct packed {
        logic [9:0] idx;
        logic       live;
        logic       sx;
        logic       sy;
        logic       ovx;
        logic       ovy;
    } side_t;

endpackage

// ===== rtl/pinhole_point_projector.sv =====
// ----------------------------------------------------------------------------
// pinhole_point_projector
// Rigid transform of a world point into the camera frame, pinhole projection
// and culling against depth and image bounds.
// ----------------------------------------------------------------------------
//  channel | direction | contents
//  s_      | in        | tdata: point_index, world_x, world_y, world_z; tuser: point_ok
//  m_      | out       | tdata: out_index, pixel_x, pixel_y; tuser: visible
//  cfg_    | in        | register write: cfg_wr_en, cfg_index, cfg_wdata
//
//  one transfer accepted per cycle unless the pipeline is full and m_tready is low
//  the pipeline is the 22-stage bit-per-stage divider plus five math stages
//  aresetn is synchronous, active low, clears valid bits and resets config registers
//  each stage holds while its successor is full and stalled, bubbles collapse
// ----------------------------------------------------------------------------
module pinhole_point_projector #(
    parameter int MAX_POINTS = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // point_index, world_x, world_y, world_z
    input  logic [0:0]  s_tuser,   // point_ok
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // out_index, pixel_x, pixel_y
    output logic [0:0]  m_tuser,   // visible
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [62:0] cfg_wdata
);

    localparam int NB = ppp_pkg::DIV_BITS;
    localparam int DW = ppp_pkg::DEN_W;
    localparam int NW = ppp_pkg::NUM_W;
    localparam int NS = NB + 5;

    // configuration
    logic [47:0] rot_x_reg, rot_y_reg, rot_z_reg;
    logic [62:0] trans_reg;
    logic [39:0] focal_reg, pp_reg;
    logic [25:0] size_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rot_x_reg <= 48'd16384;
            rot_y_reg <= 48'd1073741824;
            rot_z_reg <= 48'd70368744177664;
            trans_reg <= '0;
            focal_reg <= '0;
            pp_reg    <= '0;
            size_reg  <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                ppp_pkg::CFG_ROT_X:       rot_x_reg <= cfg_wdata[47:0];
                ppp_pkg::CFG_ROT_Y:       rot_y_reg <= cfg_wdata[47:0];
                ppp_pkg::CFG_ROT_Z:       rot_z_reg <= cfg_wdata[47:0];
                ppp_pkg::CFG_TRANSLATION: trans_reg <= cfg_wdata;
                ppp_pkg::CFG_FOCAL:       focal_reg <= cfg_wdata[39:0];
                ppp_pkg::CFG_PRINCIPAL:   pp_reg    <= cfg_wdata[39:0];
                ppp_pkg::CFG_IMAGE_SIZE:  size_reg  <= cfg_wdata[25:0];
                default: ;
            endcase
        end
    end

    logic [47:0] rot [3];
    assign rot[0] = rot_x_reg;
    assign rot[1] = rot_y_reg;
    assign rot[2] = rot_z_reg;

    // stage handshake
    logic [NS-1:0] v_reg;
    logic [NS:0]   en;

    assign en[NS] = m_tready;
    for (genvar i = 0; i < NS; i++) begin : g_valid
        assign en[i] = !v_reg[i] || en[i+1];
        if (i == 0) begin : g_head
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    v_reg[i] <= 1'b0;
                end else if (en[i]) begin
                    v_reg[i] <= s_tvalid;
                end
            end
        end else begin : g_tail
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    v_reg[i] <= 1'b0;
                end else if (en[i]) begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end
    assign s_tready = en[0];
    assign m_tvalid = v_reg[NS-1];

    // stage 0: nine lane products, first part of index wrap
    logic signed [20:0] w_in [3];
    assign w_in[0] = s_tdata[30:10];
    assign w_in[1] = s_tdata[51:31];
    assign w_in[2] = s_tdata[72:52];

    logic signed [36:0] prod_reg [3][3];
    logic [9:0]         idx0_reg, idx0_next;
    logic               ok0_reg;

    always_comb begin
        idx0_next = s_tdata[9:0];
        for (int k = 8; k >= 5; k--) begin
            if (32'(idx0_next) >= (MAX_POINTS << k)) begin
                idx0_next = 10'(32'(idx0_next) - (MAX_POINTS << k));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    prod_reg[r][c] <= 37'($signed(rot[r][16*c +: 16])) * 37'(w_in[c]);
                end
            end
            idx0_reg <= idx0_next;
            ok0_reg  <= s_tuser[0];
        end
    end

    // stage 1: camera coordinates, rest of index wrap
    logic signed [25:0] c_reg [3];
    logic [9:0]         idx1_reg, idx1_next;
    logic               ok1_reg;
    logic signed [38:0] acc [3];

    always_comb begin
        idx1_next = idx0_reg;
        for (int k = 4; k >= 0; k--) begin
            if (32'(idx1_next) >= (MAX_POINTS << k)) begin
                idx1_next = 10'(32'(idx1_next) - (MAX_POINTS << k));
            end
        end
        for (int r = 0; r < 3; r++) begin
            acc[r] = 39'(prod_reg[r][0]) + 39'(prod_reg[r][1]) + 39'(prod_reg[r][2]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            for (int r = 0; r < 3; r++) begin
                // floor shift is the arithmetic shift taken from bit 14 up
                c_reg[r] <= 26'($signed(acc[r][38:14]))
                          + 26'($signed(trans_reg[21*r +: 21]));
            end
            idx1_reg <= idx1_next;
            ok1_reg  <= ok0_reg;
        end
    end

    // stage 2: numerators
    logic signed [46:0] nx_reg, ny_reg;
    logic signed [25:0] cz_reg;
    logic [9:0]         idx2_reg;
    logic               live2_reg;

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            nx_reg    <= 47'(c_reg[0]) * 47'($signed({1'b0, focal_reg[19:0]}));
            ny_reg    <= 47'(c_reg[1]) * 47'($signed({1'b0, focal_reg[39:20]}));
            cz_reg    <= c_reg[2];
            idx2_reg  <= idx1_reg;
            live2_reg <= ok1_reg && !c_reg[2][25] && (c_reg[2] != '0);
        end
    end

    // stage 3: magnitudes and quotient overflow
    logic [46:0]        magx, magy;
    logic [DW-1:0]      den3_reg, rx3_reg, ry3_reg;
    logic [NB-1:0]      lqx3_reg, lqy3_reg;
    ppp_pkg::side_t     side3_reg;

    assign magx = nx_reg[46] ? 47'(-nx_reg) : 47'(nx_reg);
    assign magy = ny_reg[46] ? 47'(-ny_reg) : 47'(ny_reg);

    always_ff @(posedge aclk) begin
        if (en[3]) begin
            den3_reg       <= cz_reg[DW-1:0];
            rx3_reg        <= DW'(magx[NW-1:NB]);
            ry3_reg        <= DW'(magy[NW-1:NB]);
            lqx3_reg       <= magx[NB-1:0];
            lqy3_reg       <= magy[NB-1:0];
            side3_reg.idx  <= idx2_reg;
            side3_reg.live <= live2_reg;
            side3_reg.sx   <= nx_reg[46];
            side3_reg.sy   <= ny_reg[46];
            side3_reg.ovx  <= DW'(magx[NW-1:NB]) >= cz_reg[DW-1:0];
            side3_reg.ovy  <= DW'(magy[NW-1:NB]) >= cz_reg[DW-1:0];
        end
    end

    // divider stages
    logic [NB-1:0]  qx, qy;
    logic           nzx, nzy;
    ppp_pkg::side_t side_reg [NB];

    ppp_divider u_div_x (
        .aclk   (aclk),
        .en     (en[NB+3:4]),
        .den_in (den3_reg),
        .rem_in (rx3_reg),
        .lq_in  (lqx3_reg),
        .quo    (qx),
        .rem_nz (nzx)
    );

    ppp_divider u_div_y (
        .aclk   (aclk),
        .en     (en[NB+3:4]),
        .den_in (den3_reg),
        .rem_in (ry3_reg),
        .lq_in  (lqy3_reg),
        .quo    (qy),
        .rem_nz (nzy)
    );

    for (genvar j = 0; j < NB; j++) begin : g_side
        always_ff @(posedge aclk) begin
            if (en[4+j]) begin
                side_reg[j] <= (j == 0) ? side3_reg : side_reg[(j == 0) ? 0 : j-1];
            end
        end
    end

    // output stage: floor sign fix, principal point, bounds
    logic signed [23:0] qsx, qsy;
    logic signed [24:0] xq, yq;
    logic               vis_next;
    logic [9:0]         idx_out_reg;
    logic               vis_reg;
    logic [20:0]        px_reg, py_reg;
    ppp_pkg::side_t     side_last;

    assign side_last = side_reg[NB-1];

    always_comb begin
        // negative numerator rounds toward minus infinity
        qsx = side_last.sx ? $signed(24'(-{2'b0, qx} - 24'(nzx))) : $signed({2'b0, qx});
        qsy = side_last.sy ? $signed(24'(-{2'b0, qy} - 24'(nzy))) : $signed({2'b0, qy});
        xq  = 25'(qsx) + $signed({5'b0, pp_reg[19:0]});
        yq  = 25'(qsy) + $signed({5'b0, pp_reg[39:20]});
        vis_next = side_last.live && !side_last.ovx && !side_last.ovy
                && !xq[24] && !yq[24]
                && (xq[23:0] < {3'b0, size_reg[12:0], 8'b0})
                && (yq[23:0] < {3'b0, size_reg[25:13], 8'b0});
    end

    always_ff @(posedge aclk) begin
        if (en[NS-1]) begin
            idx_out_reg <= side_last.idx;
            vis_reg     <= vis_next;
            px_reg      <= vis_next ? xq[20:0] : '0;
            py_reg      <= vis_next ? yq[20:0] : '0;
        end
    end

    assign m_tdata = {4'b0, py_reg, px_reg, idx_out_reg};
    assign m_tuser = vis_reg;

`ifndef SYNTHESIS
    a_vis_in_width: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[30:10] < {size_reg[12:0], 8'b0})
        else $error("visible column outside image");

    a_hidden_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata[51:10] == '0)
        else $error("culled point carries nonzero pixels");

    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (&v_reg) && !m_tready |-> !s_tready)
        else $error("input taken while pipeline full and stalled");
`endif

endmodule

// ===== rtl/ppp_divider.sv =====
// ----------------------------------------------------------------------------
// ppp_divider
// Restoring unsigned divider, one quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
module ppp_divider (
    input  logic                             aclk,
    input  logic [ppp_pkg::DIV_BITS-1:0]     en,
    input  logic [ppp_pkg::DEN_W-1:0]        den_in,
    input  logic [ppp_pkg::DEN_W-1:0]        rem_in,
    input  logic [ppp_pkg::DIV_BITS-1:0]     lq_in,
    output logic [ppp_pkg::DIV_BITS-1:0]     quo,
    output logic                             rem_nz
);

    localparam int NB = ppp_pkg::DIV_BITS;
    localparam int DW = ppp_pkg::DEN_W;

    logic [DW-1:0] den_reg [NB];
    logic [DW-1:0] rem_reg [NB];
    logic [NB-1:0] lq_reg  [NB];

    for (genvar j = 0; j < NB; j++) begin : g_stage
        logic [DW-1:0] den_src;
        logic [DW-1:0] rem_src;
        logic [NB-1:0] lq_src;
        logic [DW:0]   trial;
        logic          ge;

        if (j == 0) begin : g_first
            assign den_src = den_in;
            assign rem_src = rem_in;
            assign lq_src  = lq_in;
        end else begin : g_next
            assign den_src = den_reg[j-1];
            assign rem_src = rem_reg[j-1];
            assign lq_src  = lq_reg[j-1];
        end

        // shift in the next numerator bit, quotient bits fill from the bottom
        assign trial = {rem_src, lq_src[NB-1]};
        assign ge    = trial >= {1'b0, den_src};

        always_ff @(posedge aclk) begin
            if (en[j]) begin
                den_reg[j] <= den_src;
                rem_reg[j] <= ge ? DW'(trial - {1'b0, den_src}) : DW'(trial);
                lq_reg[j]  <= {lq_src[NB-2:0], ge};
            end
        end
    end

    assign quo    = lq_reg[NB-1];
    assign rem_nz = rem_reg[NB-1] != '0;

endmodule

// ===== bench/ppp_checker.sv =====
// ----------------------------------------------------------------------------
// ppp_checker
// Watches the point and pixel streams and the register port, predicts each
// projected pixel and compares it with what the projector delivers.
// ----------------------------------------------------------------------------
module ppp_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [79:0] s_tdata,
    input  logic [0:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [55:0] m_tdata,
    input  logic [0:0]  m_tuser,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [62:0] cfg_wdata,
    output int          fail_count,
    output int          pending,
    output int          seen_count,
    output int          visible_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [9:0]  idx;
        logic        vis;
        logic [20:0] px;
        logic [20:0] py;
    } pixel_t;

    logic [47:0] rot_x, rot_y, rot_z;
    logic [62:0] trans;
    logic [39:0] focal, center;
    logic [25:0] img;
    pixel_t      pixel_q[$];

    function automatic longint floor_div(longint num, longint den);
        if (num >= 0) return num / den;
        return -((-num + den - 1) / den);
    endfunction

    function automatic longint cam_axis(logic [47:0] row, logic [20:0] t,
                                        longint wx, longint wy, longint wz);
        longint acc;
        acc = longint'($signed(row[15:0])) * wx + longint'($signed(row[31:16])) * wy
            + longint'($signed(row[47:32])) * wz;
        return (acc >>> 14) + longint'($signed(t));
    endfunction

    function automatic pixel_t project(logic [79:0] d, logic ok);
        pixel_t r;
        longint wx, wy, wz, cx, cy, cz, xq, yq;
        r = '0;
        r.idx = d[9:0];
        wx = longint'($signed(d[30:10]));
        wy = longint'($signed(d[51:31]));
        wz = longint'($signed(d[72:52]));
        cx = cam_axis(rot_x, trans[20:0], wx, wy, wz);
        cy = cam_axis(rot_y, trans[41:21], wx, wy, wz);
        cz = cam_axis(rot_z, trans[62:42], wx, wy, wz);
        if (ok && cz > 0) begin
            xq = floor_div(cx * longint'(focal[19:0]), cz) + longint'(center[19:0]);
            yq = floor_div(cy * longint'(focal[39:20]), cz) + longint'(center[39:20]);
            if (xq >= 0 && yq >= 0 && xq < longint'(img[12:0]) * 256
                && yq < longint'(img[25:13]) * 256) begin
                r.vis = 1'b1;
                r.px = xq[20:0];
                r.py = yq[20:0];
            end
        end
        return r;
    endfunction

    task automatic report(string what, longint got, longint want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    initial begin
        fail_count = 0;
        pending = 0;
        seen_count = 0;
        visible_count = 0;
    end

    always @(posedge aclk) begin
        pixel_t w;
        if (!aresetn) begin
            rot_x <= 48'd16384;
            rot_y <= 48'd1073741824;
            rot_z <= 48'd70368744177664;
            trans <= '0;
            focal <= '0;
            center <= '0;
            img <= '0;
        end else begin
            if (m_tvalid && m_tready) begin
                seen_count++;
                if (pixel_q.size() == 0) begin
                    report("unexpected transfer, index", m_tdata[9:0], -1);
                end else begin
                    w = pixel_q.pop_front();
                    if (m_tdata[9:0] != w.idx) report("index", m_tdata[9:0], w.idx);
                    if (m_tuser[0] != w.vis) report("visible", m_tuser[0], w.vis);
                    if (m_tdata[30:10] != w.px) report("pixel_x", m_tdata[30:10], w.px);
                    if (m_tdata[51:31] != w.py) report("pixel_y", m_tdata[51:31], w.py);
                    if (w.vis) visible_count++;
                end
            end
            if (s_tvalid && s_tready) pixel_q.push_back(project(s_tdata, s_tuser[0]));
            pending = pixel_q.size();
            if (cfg_wr_en) begin
                case (cfg_index)
                    ppp_pkg::CFG_ROT_X:       rot_x <= cfg_wdata[47:0];
                    ppp_pkg::CFG_ROT_Y:       rot_y <= cfg_wdata[47:0];
                    ppp_pkg::CFG_ROT_Z:       rot_z <= cfg_wdata[47:0];
                    ppp_pkg::CFG_TRANSLATION: trans <= cfg_wdata;
                    ppp_pkg::CFG_FOCAL:       focal <= cfg_wdata[39:0];
                    ppp_pkg::CFG_PRINCIPAL:   center <= cfg_wdata[39:0];
                    ppp_pkg::CFG_IMAGE_SIZE:  img <= cfg_wdata[25:0];
                    default: ;
                endcase
            end
        end
    end
endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Drives world points through the pinhole projector under several camera
// setups with bursty input and a stalling receiver; the checker judges.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic        aclk, aresetn;
    logic        s_tvalid, s_tready, m_tvalid, m_tready;
    logic [79:0] s_tdata;
    logic [0:0]  s_tuser, m_tuser;
    logic [55:0] m_tdata;
    logic        cfg_wr_en;
    logic [2:0]  cfg_index;
    logic [62:0] cfg_wdata;
    int          fail_count, pending, seen_count, visible_count;
    bit          stall_on;

    pinhole_point_projector dut (.*);
    ppp_checker chk (.*);

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #20ms;
        $display("Test completed with failures");
        $finish;
    end

    // receiver stall pattern: random duty in phases, with phases of none
    initial begin
        int level;
        m_tready = 1'b0;
        level = 0;
        forever begin
            @(negedge aclk);
            if ($urandom_range(0, 199) == 0) level = $urandom_range(0, 3);
            if (!stall_on) m_tready <= 1'b1;
            else case (level)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 3) != 0);
                2: m_tready <= 1'($urandom_range(0, 1));
                default: m_tready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    task automatic write_reg(ppp_pkg::cfg_index_t idx, logic [62:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic drain();
        while (pending != 0) @(negedge aclk);
        repeat (40) @(negedge aclk);
    endtask

    function automatic logic [47:0] rot_row(int a, int b, int c);
        logic [15:0] x, y, z;
        x = 16'(a); y = 16'(b); z = 16'(c);
        return {z, y, x};
    endfunction

    function automatic logic [20:0] rand_coord(int mode);
        case (mode)
            0: return 21'h100000;
            1: return 21'h0fffff;
            2: return 21'($urandom_range(0, 8191) - 4096);
            default: return 21'($urandom);
        endcase
    endfunction

    // point sender: holds tvalid across an idle draw only when sending on
    task automatic send_point(logic [9:0] idx, logic ok, logic [20:0] x,
                              logic [20:0] y, logic [20:0] z);
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, z, y, x, idx};
        s_tuser  <= ok;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic idle_gap(int n);
        s_tvalid <= 1'b0;
        s_tdata  <= 80'({$urandom, $urandom, $urandom});
        s_tuser  <= 1'($urandom);
        repeat (n) @(negedge aclk);
    endtask

    task automatic random_camera(bit narrow);
        int ang;
        ang = $urandom_range(0, 3);
        // near-identity rows (z row at times random) keep most points in front
        write_reg(ppp_pkg::CFG_ROT_X,
                  63'(rot_row(16384 - $urandom_range(0, 800), $urandom_range(0, 1600) - 800,
                              $urandom_range(0, 1600) - 800)));
        write_reg(ppp_pkg::CFG_ROT_Y,
                  63'(rot_row($urandom_range(0, 1600) - 800, 16384 - $urandom_range(0, 800),
                              $urandom_range(0, 1600) - 800)));
        write_reg(ppp_pkg::CFG_ROT_Z, ang == 0 ? 63'({$urandom, $urandom}) :
                  63'(rot_row($urandom_range(0, 1600) - 800, $urandom_range(0, 1600) - 800,
                              16384 - $urandom_range(0, 800))));
        write_reg(ppp_pkg::CFG_TRANSLATION, {21'($urandom_range(0, 40960)),
                                             21'($urandom_range(0, 8192) - 4096),
                                             21'($urandom_range(0, 8192) - 4096)});
        write_reg(ppp_pkg::CFG_FOCAL, 63'({20'($urandom_range(25600, 204800)),
                                           20'($urandom_range(25600, 204800))}));
        write_reg(ppp_pkg::CFG_PRINCIPAL, 63'({20'($urandom_range(0, 163840)),
                                               20'($urandom_range(0, 163840))}));
        write_reg(ppp_pkg::CFG_IMAGE_SIZE,
                  narrow ? 63'({13'($urandom_range(1, 8)), 13'($urandom_range(1, 8))})
                         : 63'({13'($urandom_range(320, 8191)),
                                13'($urandom_range(240, 8191))}));
    endtask

    initial begin
        int n, burst, mode;
        logic [20:0] z;
        stall_on = 0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        cfg_wr_en = 1'b0;
        cfg_index = ppp_pkg::CFG_ROT_X;
        cfg_wdata = '0;
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset registers: zero image culls everything
        send_point(10'd0, 1'b1, 21'd4096, 21'd4096, 21'd4096);
        send_point(10'h3ff, 1'b0, 21'h100000, 21'h0fffff, 21'h0fffff);
        idle_gap(1);
        drain();

        // identity pose, 640x480 camera, extreme constants
        write_reg(ppp_pkg::CFG_FOCAL, 63'({20'd128000, 20'd128000}));
        write_reg(ppp_pkg::CFG_PRINCIPAL, 63'({20'd81920, 20'd61440}));
        write_reg(ppp_pkg::CFG_IMAGE_SIZE, 63'({13'd480, 13'd640}));
        send_point(10'd1, 1'b1, 21'd0, 21'd0, 21'd4096);           // center
        send_point(10'd2, 1'b0, 21'd0, 21'd0, 21'd4096);           // invalid
        send_point(10'd3, 1'b1, 21'd0, 21'd0, 21'd0);              // zero depth
        send_point(10'd4, 1'b1, 21'd100, 21'd100, -21'sd4096);     // behind
        send_point(10'd5, 1'b1, 21'h0fffff, 21'h0fffff, 21'd1);    // huge quotient
        send_point(10'd6, 1'b1, 21'h100000, 21'h100000, 21'd1);
        send_point(10'd7, 1'b1, -21'sd2000, -21'sd1500, 21'd4096); // top left edge
        send_point(10'd8, 1'b1, 21'd2048, 21'd1536, 21'd4096);     // right edge
        send_point(10'h3ff, 1'b1, 21'h100000, 21'h0fffff, 21'h0fffff);
        idle_gap(1);
        drain();

        // zero focal: onto the principal point
        write_reg(ppp_pkg::CFG_FOCAL, 63'd0);
        send_point(10'd9, 1'b1, 21'd999, -21'sd777, 21'd300);
        idle_gap(1);
        drain();

        // every bit at its extremes
        write_reg(ppp_pkg::CFG_ROT_X, 63'({48{1'b1}}));
        write_reg(ppp_pkg::CFG_ROT_Y, 63'(48'h8000_8000_8000));
        write_reg(ppp_pkg::CFG_ROT_Z, 63'(48'h7fff_7fff_7fff));
        write_reg(ppp_pkg::CFG_TRANSLATION, {63{1'b1}});
        write_reg(ppp_pkg::CFG_FOCAL, 63'({40{1'b1}}));
        write_reg(ppp_pkg::CFG_PRINCIPAL, 63'({40{1'b1}}));
        write_reg(ppp_pkg::CFG_IMAGE_SIZE, 63'({26{1'b1}}));
        write_reg(ppp_pkg::cfg_index_t'(3'd7), {63{1'b1}});
        send_point(10'd10, 1'b1, 21'h0fffff, 21'h0fffff, 21'h0fffff);
        send_point(10'd11, 1'b1, 21'h100000, 21'h100000, 21'h100000);
        send_point(10'd12, 1'b1, 21'h100000, 21'h0fffff, 21'h100000);
        idle_gap(1);
        drain();

        stall_on = 1;
        for (int phase = 0; phase < 8; phase++) begin
            random_camera(phase == 5);
            n = 0;
            while (n < 106) begin
                burst = $urandom_range(1, 20);
                for (int k = 0; k < burst && n < 106; k++) begin
                    mode = $urandom_range(0, 19);
                    // mostly positive depth in front of the camera
                    z = (mode < 16) ? 21'($urandom_range(2048, 131072)) : rand_coord(mode & 3);
                    send_point(10'($urandom), $urandom_range(0, 15) != 0,
                               mode < 16 ? rand_coord(2) : rand_coord(mode & 3),
                               mode < 16 ? rand_coord(2) : rand_coord(mode & 3), z);
                    n++;
                end
                if ($urandom_range(0, 1)) idle_gap($urandom_range(1, 12));
                if ($urandom_range(0, 40) == 0) begin
                    idle_gap(1);
                    while (pending != 0) @(negedge aclk);
                end
            end
            idle_gap(1);
            drain();
        end

        $display("checked %0d projected points, %0d of them visible", seen_count, visible_count);
        $display("camera setups: reset, identity, zero focal, extremes, eight random poses");
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
